// ----- design/ist_pkg.sv -----
`timescale 1ns / 1ps
package ist_pkg;

    localparam int UNIVERSE_BITS_DEF = 16;
    localparam int WORD_LOG_MAX      = 6;
    localparam int VALUE_W           = 16;
    localparam int CMD_W             = 2;
    localparam int S_TDATA_W         = 24;
    localparam int M_TDATA_W         = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CSCAN,
        ST_MINSUM,
        ST_MINCL,
        ST_MAXSUM,
        ST_MAXCL,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic               is_empty;
        logic [VALUE_W-1:0] max_value;
        logic [VALUE_W-1:0] min_value;
        logic               was_member;
    } result_t;

    function automatic logic [WORD_LOG_MAX-1:0] lowest_one(input logic [63:0] w);
        logic [WORD_LOG_MAX-1:0] pos;
        pos = '0;
        for (int i = 63; i >= 0; i--) begin
            if (w[i]) begin
                pos = WORD_LOG_MAX'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [WORD_LOG_MAX-1:0] highest_one(input logic [63:0] w);
        logic [WORD_LOG_MAX-1:0] pos;
        pos = '0;
        for (int i = 0; i < 64; i++) begin
            if (w[i]) begin
                pos = WORD_LOG_MAX'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- design/ist_ram.sv -----
`timescale 1ns / 1ps
module ist_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ist_seq.sv -----
`timescale 1ns / 1ps
module ist_seq #(
    parameter int UNIVERSE_BITS = ist_pkg::UNIVERSE_BITS_DEF,
    parameter int WORD_W        = 64,
    parameter int MEM_AW        = 10,
    parameter int SUM_W         = 16,
    parameter int SUM_AW        = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ist_pkg::CMD_W-1:0]  in_command,
    input  logic [ist_pkg::VALUE_W-1:0] in_value,
    output logic                       mem_we,
    output logic [MEM_AW-1:0]          mem_waddr,
    output logic [WORD_W-1:0]          mem_wdata,
    output logic [MEM_AW-1:0]          mem_raddr,
    input  logic [WORD_W-1:0]          mem_rdata,
    output logic                       sum_we,
    output logic [SUM_AW-1:0]          sum_waddr,
    output logic [SUM_W-1:0]           sum_wdata,
    output logic [SUM_AW-1:0]          sum_raddr,
    input  logic [SUM_W-1:0]           sum_rdata,
    output logic                       res_valid,
    input  logic                       res_free,
    output ist_pkg::result_t           res
);
    import ist_pkg::*;

    localparam int UB        = UNIVERSE_BITS;
    localparam int LOW_BITS  = UB / 2;
    localparam int HIGH_BITS = UB - LOW_BITS;
    localparam int WLOG      = (LOW_BITS < WORD_LOG_MAX) ? LOW_BITS : WORD_LOG_MAX;
    localparam int CW_LOG    = LOW_BITS - WLOG;
    localparam int CPW       = 1 << CW_LOG;
    localparam int SLOG      = (HIGH_BITS < WORD_LOG_MAX) ? HIGH_BITS : WORD_LOG_MAX;
    localparam int SD_LOG    = HIGH_BITS - SLOG;
    localparam int SUM_DEPTH = 1 << SD_LOG;
    localparam int CNT_W0    = (CW_LOG > SD_LOG) ? CW_LOG : SD_LOG;
    localparam int CNT_W     = (CNT_W0 > 0) ? CNT_W0 : 1;

    seq_state_t           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [UB-1:0]        v_reg, v_next;
    logic [HIGH_BITS-1:0] clus_reg, clus_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 prim_reg, prim_next;
    logic                 was_reg, was_next;
    logic [SUM_W-1:0]     sword_reg, sword_next;
    logic [UB-1:0]        low_reg, low_next;
    logic [UB-1:0]        high_reg, high_next;
    logic                 empty_reg, empty_next;
    logic [MEM_AW-1:0]    clr_reg, clr_next;

    logic [HIGH_BITS-1:0] v_hi;
    logic [WLOG-1:0]      v_bit;
    logic [SLOG-1:0]      s_bit;
    logic [SUM_AW-1:0]    s_word;
    logic                 fwd;
    logic [CNT_W-1:0]     rd_cnt;
    logic [CNT_W-1:0]     cl_idx, sm_idx, rd_cl_idx, rd_sm_idx;
    logic                 cl_last, sm_last;
    logic                 mem_hit, sum_hit;
    logic [WLOG-1:0]      mem_pos;
    logic [SLOG-1:0]      sum_pos;
    logic [HIGH_BITS-1:0] found_clus;
    logic [UB-1:0]        found_val;
    logic                 go_min, go_max;
    logic [WORD_W-1:0]    v_mask;
    logic [SUM_W-1:0]     s_mask;
    logic                 in_hit;

    assign v_hi    = v_reg[UB-1:LOW_BITS];
    assign v_bit   = v_reg[WLOG-1:0];
    assign s_bit   = v_hi[SLOG-1:0];
    assign s_word  = SUM_AW'(v_hi >> SLOG);
    assign v_mask  = WORD_W'(1) << v_bit;
    assign s_mask  = SUM_W'(1) << s_bit;
    assign fwd     = state_reg inside {ST_CSCAN, ST_MINSUM, ST_MINCL};
    assign rd_cnt  = prim_reg ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cl_idx  = fwd ? cnt_reg : CNT_W'(CPW - 1) - cnt_reg;
    assign sm_idx  = fwd ? cnt_reg : CNT_W'(SUM_DEPTH - 1) - cnt_reg;
    assign rd_cl_idx = fwd ? rd_cnt : CNT_W'(CPW - 1) - rd_cnt;
    assign rd_sm_idx = fwd ? rd_cnt : CNT_W'(SUM_DEPTH - 1) - rd_cnt;
    assign cl_last = (cnt_reg == CNT_W'(CPW - 1));
    assign sm_last = (cnt_reg == CNT_W'(SUM_DEPTH - 1));
    assign mem_hit = (mem_rdata != '0);
    assign sum_hit = (sum_rdata != '0);
    assign mem_pos = fwd ? WLOG'(lowest_one(64'(mem_rdata)))
                         : WLOG'(highest_one(64'(mem_rdata)));
    assign sum_pos = fwd ? SLOG'(lowest_one(64'(sum_rdata)))
                         : SLOG'(highest_one(64'(sum_rdata)));
    assign found_clus = (HIGH_BITS'(sm_idx) << SLOG) | HIGH_BITS'(sum_pos);
    assign found_val  = (UB'(clus_reg) << LOW_BITS) | (UB'(cl_idx) << WLOG) | UB'(mem_pos);
    assign go_min  = (v_reg == low_reg);
    assign go_max  = (v_reg == high_reg);
    assign in_hit  = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            empty_reg <= 1'b1;
            prim_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            empty_reg <= empty_next;
            prim_reg  <= prim_next;
        end
        cmd_reg   <= cmd_next;
        v_reg     <= v_next;
        clus_reg  <= clus_next;
        cnt_reg   <= cnt_next;
        was_reg   <= was_next;
        sword_reg <= sword_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        v_next     = v_reg;
        clus_next  = clus_reg;
        cnt_next   = cnt_reg;
        prim_next  = prim_reg;
        was_next   = was_reg;
        sword_next = sword_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        empty_next = empty_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = v_reg[UB-1:WLOG];
        mem_wdata  = mem_rdata;
        sum_we     = 1'b0;
        sum_waddr  = s_word;
        sum_wdata  = sword_reg;
        mem_raddr  = (MEM_AW'(clus_reg) << CW_LOG) + MEM_AW'(rd_cl_idx);
        sum_raddr  = SUM_AW'(rd_sm_idx);
        res.was_member = was_reg;
        res.min_value  = VALUE_W'(low_reg);
        res.max_value  = VALUE_W'(high_reg);
        res.is_empty   = empty_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                sum_we    = (clr_reg <= MEM_AW'(SUM_DEPTH - 1));
                sum_waddr = SUM_AW'(clr_reg);
                sum_wdata = '0;
                clr_next  = clr_reg + MEM_AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready  = 1'b1;
                mem_raddr = MEM_AW'(UB'(in_value) >> WLOG);
                sum_raddr = SUM_AW'(UB'(in_value) >> (LOW_BITS + SLOG));
                if (in_hit) begin
                    cmd_next   = cmd_t'(in_command);
                    v_next     = UB'(in_value);
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                was_next   = mem_rdata[v_bit];
                sword_next = sum_rdata;
                clus_next  = v_hi;
                cnt_next   = '0;
                prim_next  = 1'b0;
                state_next = ST_DONE;
                if (cmd_reg == CMD_INSERT && !mem_rdata[v_bit]) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | v_mask;
                    sum_we    = 1'b1;
                    sum_wdata = sum_rdata | s_mask;
                    if (empty_reg) begin
                        low_next   = v_reg;
                        high_next  = v_reg;
                        empty_next = 1'b0;
                    end else begin
                        if (v_reg < low_reg) begin
                            low_next = v_reg;
                        end
                        if (v_reg > high_reg) begin
                            high_next = v_reg;
                        end
                    end
                end else if (cmd_reg == CMD_REMOVE && mem_rdata[v_bit]) begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata & ~v_mask;
                    state_next = ST_CSCAN;
                end
            end
            ST_CSCAN, ST_MINCL, ST_MAXCL: begin
                if (!prim_reg) begin
                    prim_next = 1'b1;
                end else if (mem_hit || cl_last) begin
                    prim_next = 1'b0;
                    cnt_next  = '0;
                    if (state_reg == ST_CSCAN) begin
                        if (!mem_hit) begin
                            sum_we    = 1'b1;
                            sum_wdata = sword_reg & ~s_mask;
                        end
                        state_next = go_min ? ST_MINSUM : (go_max ? ST_MAXSUM : ST_DONE);
                    end else if (state_reg == ST_MINCL) begin
                        if (mem_hit) begin
                            low_next = found_val;
                        end
                        state_next = go_max ? ST_MAXSUM : ST_DONE;
                    end else begin
                        if (mem_hit) begin
                            high_next = found_val;
                        end
                        state_next = ST_DONE;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MINSUM, ST_MAXSUM: begin
                if (!prim_reg) begin
                    prim_next = 1'b1;
                end else if (sum_hit) begin
                    prim_next  = 1'b0;
                    cnt_next   = '0;
                    clus_next  = found_clus;
                    state_next = (state_reg == ST_MINSUM) ? ST_MINCL : ST_MAXCL;
                end else if (sm_last) begin
                    prim_next  = 1'b0;
                    empty_next = 1'b1;
                    low_next   = '0;
                    high_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_hit |=> state_reg == ST_LOOKUP)
        else $error("accepted transaction did not start a lookup");
    a_empty_marks_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (low_reg == '0 && high_reg == '0))
        else $error("empty set with nonzero extremes");
    a_marks_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_reg |-> low_reg <= high_reg)
        else $error("minimum above maximum");
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !res_valid && !in_ready)
        else $error("traffic during clearing pass");
`endif

endmodule

// ----- design/integer_set_min_max_tracker.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Width  Fields (lsb first)
// s_axis   in   24     command[1:0], value[17:2]
// m_axis   out  40     was_member[0], min_value[16:1], max_value[32:17], is_empty[33]
//
// Insert and query pass through the lookup and done states from accept to result register.
// Removing a member adds a scan of the value's cluster, and when the removed value
// was an extreme, a summary scan plus a cluster scan unless the set is left empty.
// After reset a clearing pass writes every member word once; s_tready stays low meanwhile.
// The result register lets the next transaction in while m_axis stalls.
module integer_set_min_max_tracker #(
    parameter int UNIVERSE_BITS = ist_pkg::UNIVERSE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ist_pkg::S_TDATA_W-1:0] s_tdata,  // command, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ist_pkg::M_TDATA_W-1:0] m_tdata   // was_member, min_value, max_value, is_empty
);
    import ist_pkg::*;

    localparam int LOW_BITS  = UNIVERSE_BITS / 2;
    localparam int HIGH_BITS = UNIVERSE_BITS - LOW_BITS;
    localparam int WLOG      = (LOW_BITS < WORD_LOG_MAX) ? LOW_BITS : WORD_LOG_MAX;
    localparam int WORD_W    = 1 << WLOG;
    localparam int MEM_AW    = UNIVERSE_BITS - WLOG;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int SLOG      = (HIGH_BITS < WORD_LOG_MAX) ? HIGH_BITS : WORD_LOG_MAX;
    localparam int SUM_W     = 1 << SLOG;
    localparam int SD_LOG    = HIGH_BITS - SLOG;
    localparam int SUM_DEPTH = 1 << SD_LOG;
    localparam int SUM_AW    = (SD_LOG > 0) ? SD_LOG : 1;

    logic              mem_we, sum_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic [SUM_AW-1:0] sum_waddr, sum_raddr;
    logic [SUM_W-1:0]  sum_wdata, sum_rdata;
    logic              res_valid, res_free;
    result_t           res;
    logic              m_tvalid_reg;
    result_t           m_res_reg;

    ist_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH), .ADDR_W(MEM_AW)) u_member_ram (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    ist_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH), .ADDR_W(SUM_AW)) u_summary_ram (
        .aclk(aclk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    ist_seq #(
        .UNIVERSE_BITS(UNIVERSE_BITS), .WORD_W(WORD_W), .MEM_AW(MEM_AW),
        .SUM_W(SUM_W), .SUM_AW(SUM_AW)
    ) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_command(s_tdata[CMD_W-1:0]), .in_value(s_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
        .sum_we(sum_we), .sum_waddr(sum_waddr), .sum_wdata(sum_wdata),
        .sum_raddr(sum_raddr), .sum_rdata(sum_rdata),
        .res_valid(res_valid), .res_free(res_free), .res(res)
    );

    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_free) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg);

endmodule
